>>> hdl/lst_pkg.sv
// ----------------------------------------------------------------------------
// lst_pkg: shared types for the bounded list store
// Operation and status codes, controller states, and the command and status
// groups that pass between the list controller and its datapath.
// ----------------------------------------------------------------------------
package lst_pkg;

  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 2;

  typedef enum logic [KIND_W-1:0] {
    K_INS_FRONT = 3'd0,
    K_INS_REAR  = 3'd1,
    K_DEL_FRONT = 3'd2,
    K_DEL_REAR  = 3'd3,
    K_DEL_POS   = 3'd4,
    K_DUMP      = 3'd5
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_LINK,
    S_SEEK,
    S_UNLINK,
    S_DUMP,
    S_RESP
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic    start;      // latch the operation, point the cursor at the head
    logic    insert;     // write the new slot, pop a free slot
    logic    link_tail;  // rear insert: hook the new slot behind the old tail
    logic    del_head;   // remove the head node
    logic    seek_init;  // start the walk toward the predecessor
    logic    advance;    // cursor steps one node
    logic    grab;       // predecessor found, cursor moves onto the victim
    logic    unlink;     // bypass the victim and free it
    logic    dump_out;   // send the node under the cursor
    logic    resp_set;   // load an error or empty response
    status_e resp_status;
    logic    resp_out;   // send the pending response
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    kind_e kind;
    logic  full;
    logic  empty;
    logic  pos_bad;
    logic  pos_first;
    logic  at_target;
    logic  at_end;
    logic  rear_link;
    logic  out_free;
  } stat_t;

endpackage

>>> hdl/lst_controller.sv
// ----------------------------------------------------------------------------
// lst_controller: sequencer of the bounded list store
// Decodes the latched operation and steps the datapath through inserts,
// list walks, unlinks and dumps.
// ----------------------------------------------------------------------------
module lst_controller (
  input  logic          clk,
  input  logic          rst,
  input  logic          op_valid,
  output logic          op_ready,
  input  lst_pkg::stat_t stat,
  output lst_pkg::cmd_t  cmd
);
  import lst_pkg::*;

  state_e state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (op_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (stat.kind)
          K_INS_FRONT, K_INS_REAR: begin
            if (!stat.full && stat.rear_link) state_next = S_LINK;
            else state_next = S_RESP;
          end
          K_DEL_FRONT, K_DEL_REAR, K_DEL_POS: begin
            if (stat.empty) state_next = S_RESP;
            else if (stat.kind == K_DEL_POS && stat.pos_bad) state_next = S_RESP;
            else if (stat.pos_first) state_next = S_RESP;
            else state_next = S_SEEK;
          end
          K_DUMP: begin
            if (stat.empty) state_next = S_RESP;
            else state_next = S_DUMP;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_LINK:   state_next = S_RESP;
      S_SEEK: begin
        if (stat.at_target) state_next = S_UNLINK;
      end
      S_UNLINK: state_next = S_RESP;
      S_DUMP: begin
        if (stat.out_free && stat.at_end) state_next = S_IDLE;
      end
      S_RESP: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    op_ready = 1'b0;
    case (state)
      S_IDLE: begin
        op_ready  = 1'b1;
        cmd.start = op_valid;
      end
      S_DECODE: begin
        case (stat.kind)
          K_INS_FRONT, K_INS_REAR: begin
            if (stat.full) begin
              cmd.resp_set    = 1'b1;
              cmd.resp_status = ST_FULL;
            end else begin
              cmd.insert = 1'b1;
            end
          end
          K_DEL_FRONT, K_DEL_REAR, K_DEL_POS: begin
            if (stat.empty) begin
              cmd.resp_set    = 1'b1;
              cmd.resp_status = ST_EMPTY;
            end else if (stat.kind == K_DEL_POS && stat.pos_bad) begin
              cmd.resp_set    = 1'b1;
              cmd.resp_status = ST_RANGE;
            end else if (stat.pos_first) begin
              cmd.del_head = 1'b1;
            end else begin
              cmd.seek_init = 1'b1;
            end
          end
          K_DUMP: begin
            if (stat.empty) begin
              cmd.resp_set    = 1'b1;
              cmd.resp_status = ST_EMPTY;
            end
          end
          default: cmd = '0;
        endcase
      end
      S_LINK:   cmd.link_tail = 1'b1;
      S_SEEK: begin
        if (stat.at_target) cmd.grab = 1'b1;
        else cmd.advance = 1'b1;
      end
      S_UNLINK: cmd.unlink = 1'b1;
      S_DUMP:   cmd.dump_out = stat.out_free;
      S_RESP:   cmd.resp_out = stat.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

>>> hdl/lst_datapath.sv
// ----------------------------------------------------------------------------
// lst_datapath: storage and pointers of the bounded list store
// Element and link memories, a free-slot stack, head/tail/count registers,
// the walking cursor and the result register.
// ----------------------------------------------------------------------------
module lst_datapath #(
  parameter int CAPACITY = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  lst_pkg::cmd_t                         cmd,
  output lst_pkg::stat_t                        stat,
  input  logic [lst_pkg::KIND_W-1:0]            kind,
  input  logic signed [lst_pkg::VALUE_W-1:0]    value,
  input  logic [lst_pkg::POS_W-1:0]             position,
  output logic                                  result_valid,
  input  logic                                  result_ready,
  output logic [lst_pkg::STATUS_W-1:0]          status,
  output logic signed [lst_pkg::VALUE_W-1:0]    element,
  output logic                                  last,
  output logic [$clog2(CAPACITY+1)-1:0]         length
);
  import lst_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = $clog2(CAPACITY);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] NULL_LINK = CW'(CAPACITY);

  logic signed [VALUE_W-1:0] elem_mem [CAPACITY];
  logic [CW-1:0]             link_mem [CAPACITY];
  logic [SW-1:0]             free_mem [CAPACITY];
  logic signed [VALUE_W-1:0] elem_q;
  logic [CW-1:0]             link_q;
  logic [SW-1:0]             free_q;

  kind_e                     kind_r;
  logic signed [VALUE_W-1:0] value_r;
  logic [POS_W-1:0]          position_r;

  logic [CW-1:0] head, tail, count, fill, ftop;
  logic [CW-1:0] cur, cur_next, prv, idx, tgt;
  logic [SW-1:0] slot;

  status_e                   resp_status;
  logic signed [VALUE_W-1:0] resp_element;

  logic [SW-1:0] new_slot;
  logic [SW-1:0] rd_addr;
  logic [SW-1:0] free_raddr;
  logic [PW-1:0] pos_sel;
  logic          empty;
  logic          link_we;
  logic [SW-1:0] link_waddr;
  logic [CW-1:0] link_wdata;
  logic          push;
  logic          load;

  assign empty      = (count == '0);
  assign new_slot   = (ftop != '0) ? free_q : fill[SW-1:0];
  assign free_raddr = SW'(ftop - CW'(1));
  assign push       = cmd.del_head | cmd.unlink;
  assign load       = cmd.resp_out | cmd.dump_out;

  always_comb begin
    case (kind_r)
      K_DEL_REAR: pos_sel = PW'(count);
      K_DEL_POS:  pos_sel = PW'(position_r);
      default:    pos_sel = PW'(1);
    endcase
  end

  assign stat.kind      = kind_r;
  assign stat.full      = (count == NULL_LINK);
  assign stat.empty     = empty;
  assign stat.pos_bad   = (position_r == '0) || (PW'(position_r) > PW'(count));
  assign stat.pos_first = (pos_sel == PW'(1));
  assign stat.at_target = (idx == tgt);
  assign stat.at_end    = (link_q == NULL_LINK);
  assign stat.rear_link = (kind_r == K_INS_REAR) && !empty;
  assign stat.out_free  = !result_valid || result_ready;

  // The memories are always read at the cursor's next value, so the read
  // data show the node under the cursor once the cursor register holds it.
  always_comb begin
    cur_next = cur;
    if (cmd.start) cur_next = head;
    else if (cmd.advance || cmd.grab || cmd.dump_out) cur_next = link_q;
  end
  assign rd_addr = cur_next[SW-1:0];

  always_comb begin
    link_we    = 1'b0;
    link_waddr = new_slot;
    link_wdata = head;
    if (cmd.insert) begin
      link_we    = 1'b1;
      link_waddr = new_slot;
      link_wdata = ((kind_r == K_INS_FRONT) || empty) ? head : NULL_LINK;
    end else if (cmd.link_tail) begin
      link_we    = 1'b1;
      link_waddr = tail[SW-1:0];
      link_wdata = CW'(slot);
    end else if (cmd.unlink) begin
      link_we    = 1'b1;
      link_waddr = prv[SW-1:0];
      link_wdata = link_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) elem_mem[new_slot] <= value_r;
    elem_q <= elem_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_waddr] <= link_wdata;
    link_q <= link_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (push) free_mem[ftop[SW-1:0]] <= cur[SW-1:0];
    free_q <= free_mem[free_raddr];
  end

  // list bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= NULL_LINK;
      tail  <= NULL_LINK;
      count <= '0;
      fill  <= '0;
      ftop  <= '0;
    end else begin
      if (cmd.insert) begin
        if ((kind_r == K_INS_FRONT) || empty) head <= CW'(new_slot);
        if (empty) tail <= CW'(new_slot);
        count <= count + CW'(1);
        if (ftop != '0) ftop <= ftop - CW'(1);
        else fill <= fill + CW'(1);
      end
      if (cmd.link_tail) tail <= CW'(slot);
      if (cmd.del_head) head <= link_q;
      if (cmd.unlink && (cur == tail)) tail <= prv;
      if (push) begin
        count <= count - CW'(1);
        ftop  <= ftop + CW'(1);
      end
    end
  end

  // operation and walk registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      kind_r     <= kind_e'(kind);
      value_r    <= value;
      position_r <= position;
    end
    cur <= cur_next;
    if (cmd.grab) prv <= cur;
    if (cmd.insert) slot <= new_slot;
    if (cmd.seek_init) begin
      idx <= CW'(1);
      tgt <= CW'(pos_sel - PW'(1));
    end else if (cmd.advance) begin
      idx <= idx + CW'(1);
    end
    if (cmd.resp_set) begin
      resp_status  <= cmd.resp_status;
      resp_element <= '0;
    end else if (cmd.insert) begin
      resp_status  <= ST_OK;
      resp_element <= '0;
    end else if (push) begin
      resp_status  <= ST_OK;
      resp_element <= elem_q;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status  <= cmd.resp_out ? resp_status : ST_OK;
      element <= cmd.resp_out ? resp_element : elem_q;
      last    <= cmd.resp_out ? 1'b1 : (link_q == NULL_LINK);
      length  <= count;
    end
  end

endmodule

>>> hdl/bounded_list_store.sv
// ----------------------------------------------------------------------------
// bounded_list_store: ordered list of up to CAPACITY signed 32-bit values
// An operation beat (kind, value, position) enters on op_valid/op_ready.
// Every operation but the two unused kind codes answers on result_valid/
// result_ready: one beat, or one beat per element for a dump, the final beat
// marked by last. length is the element count after the operation.
// op_ready is high only while no operation is in progress. An insert at the
// rear of a non-empty list adds a step that links the old tail to the new
// node. A delete at position p (rear delete: p = length) removes the head
// directly for p = 1; else it walks from the head to the predecessor, one
// node per cycle through the link memory, then unlinks the victim. A dump
// sends one beat per cycle while the receiver is ready. Errors skip the walk.
// A finished answer waits in the output register, so the next operation can
// be taken while it is still pending; a stalled receiver stops a dump in
// place until it takes the beat. Reset (synchronous, active high) empties
// the list; no memory clearing is needed.
// ----------------------------------------------------------------------------
module bounded_list_store #(
  parameter int CAPACITY = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  op_valid,
  output logic                                  op_ready,
  input  logic [lst_pkg::KIND_W-1:0]            kind,
  input  logic signed [lst_pkg::VALUE_W-1:0]    value,
  input  logic [lst_pkg::POS_W-1:0]             position,
  output logic                                  result_valid,
  input  logic                                  result_ready,
  output logic [lst_pkg::STATUS_W-1:0]          status,
  output logic signed [lst_pkg::VALUE_W-1:0]    element,
  output logic                                  last,
  output logic [$clog2(CAPACITY+1)-1:0]         length
);
  import lst_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lst_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lst_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .kind         (kind),
    .value        (value),
    .position     (position),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .element      (element),
    .last         (last),
    .length       (length)
  );

endmodule

>>> hdl/lst_checker.sv
// ----------------------------------------------------------------------------
// lst_checker: port-level checks for the bounded list store
// Watches both channels and the reported length and status codes.
// ----------------------------------------------------------------------------
module lst_checker #(
  parameter int CAPACITY = 16
) (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  op_valid,
  input logic                                  op_ready,
  input logic                                  result_valid,
  input logic                                  result_ready,
  input logic [lst_pkg::STATUS_W-1:0]          status,
  input logic signed [lst_pkg::VALUE_W-1:0]    element,
  input logic                                  last,
  input logic [$clog2(CAPACITY+1)-1:0]         length
);
  import lst_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  // a pending result beat holds until taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(status) && $stable(element) && $stable(last) &&
      $stable(length))
    else $error("result beat changed while stalled");

  // one operation at a time
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    op_valid && op_ready |=> !op_ready)
    else $error("operation accepted while another is in progress");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> length <= CW'(CAPACITY))
    else $error("length beyond capacity");

  a_full_len: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == ST_FULL) |-> length == CW'(CAPACITY))
    else $error("full reported with room left");

  // only dump beats come without last, and those are always ok
  a_mid_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |-> status == ST_OK && length != '0)
    else $error("non-final beat with error status");

endmodule

bind bounded_list_store lst_checker #(.CAPACITY(CAPACITY)) u_lst_checker (.*);

>>> test/bounded_list_store_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_list_store_test: self-checking bench for the bounded list store
// A table of directed operations (empty, full and range errors, extreme
// values, unused kinds, a full fill and dumps) runs first. Random operations
// follow, with the fill level steered up and down. Every answer beat is checked
// against a queue-based model of the list or a typed row's own answer. Both
// handshakes idle and stall at random, with one long stretch where neither side does.
// ----------------------------------------------------------------------------
module bounded_list_store_test;
  import lst_pkg::*;

  localparam int CAPACITY   = 16;
  localparam int LEN_W      = $clog2(CAPACITY + 1);
  localparam int RANDOM_OPS = 370;

  // the two kind codes the block ignores
  localparam logic [KIND_W-1:0] K_UNUSED_LO = 3'd6;
  localparam logic [KIND_W-1:0] K_UNUSED_HI = 3'd7;

  localparam logic [VALUE_W-1:0] V_MAX = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] V_MIN = 32'h8000_0000;

  typedef struct packed {
    status_e                    status;
    logic signed [VALUE_W-1:0]  element;
    logic                       last;
    logic [LEN_W-1:0]           length;
  } answer_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   position;
    logic [4:0]         reps;
    logic               typed;
    answer_t            answer;
  } step_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        op_valid = 1'b0;
  logic                        op_ready;
  logic [KIND_W-1:0]           kind = '0;
  logic signed [VALUE_W-1:0]   value = '0;
  logic [POS_W-1:0]            position = '0;
  logic                        result_valid;
  logic                        result_ready = 1'b0;
  logic [STATUS_W-1:0]         status;
  logic signed [VALUE_W-1:0]   element;
  logic                        last;
  logic [LEN_W-1:0]            length;

  logic signed [VALUE_W-1:0] list_values[$];
  answer_t                   op_answers[$];
  answer_t                   pending_answers[$];
  step_t                     steps[$];
  int                        gap_pct = 23;
  int                        err_count = 0;

  bounded_list_store #(.CAPACITY(CAPACITY)) i_dut (
    .clk          (clk),
    .rst          (rst),
    .op_valid     (op_valid),
    .op_ready     (op_ready),
    .kind         (kind),
    .value        (value),
    .position     (position),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .element      (element),
    .last         (last),
    .length       (length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("bounded_list_store test failed");
    $finish;
  end

  // Computes the answer beats of one operation and updates the list copy.
  function automatic void predict_answers(input logic [KIND_W-1:0] k,
                                          input logic signed [VALUE_W-1:0] v,
                                          input logic [POS_W-1:0] p);
    int      cnt;
    answer_t a;
    op_answers.delete();
    cnt = list_values.size();
    a.status  = ST_OK;
    a.element = '0;
    a.last    = 1'b1;
    case (k)
      K_INS_FRONT, K_INS_REAR: begin
        if (cnt >= CAPACITY) a.status = ST_FULL;
        else if (k == K_INS_FRONT) list_values.push_front(v);
        else list_values.push_back(v);
        a.length = LEN_W'(list_values.size());
        op_answers.push_back(a);
      end
      K_DEL_FRONT, K_DEL_REAR, K_DEL_POS: begin
        // empty wins over a bad position
        if (cnt == 0) a.status = ST_EMPTY;
        else if (k == K_DEL_FRONT) a.element = list_values.pop_front();
        else if (k == K_DEL_REAR) a.element = list_values.pop_back();
        else if (p == 0 || p > cnt) a.status = ST_RANGE;
        else begin
          a.element = list_values[p - 1];
          list_values.delete(p - 1);
        end
        a.length = LEN_W'(list_values.size());
        op_answers.push_back(a);
      end
      K_DUMP: begin
        a.length = LEN_W'(cnt);
        if (cnt == 0) begin
          a.status = ST_EMPTY;
          op_answers.push_back(a);
        end else begin
          for (int i = 0; i < cnt; i++) begin
            a.element = list_values[i];
            a.last    = (i == cnt - 1);
            op_answers.push_back(a);
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic add_step(input logic [KIND_W-1:0] k, input logic [VALUE_W-1:0] v,
                          input logic [POS_W-1:0] p, input int reps, input int typed,
                          input status_e st, input logic [VALUE_W-1:0] el,
                          input int len);
    step_t s;
    s.kind     = k;
    s.value    = v;
    s.position = p;
    s.reps     = 5'(reps);
    s.typed    = (typed != 0);
    s.answer   = '{st, el, 1'b1, LEN_W'(len)};
    steps.push_back(s);
  endtask

  // Presents one operation beat and returns at the edge that accepts it.
  task automatic drive_op(input logic [KIND_W-1:0] k, input logic [VALUE_W-1:0] v,
                          input logic [POS_W-1:0] p);
    while ($urandom_range(0, 99) < gap_pct) begin
      op_valid <= 1'b0;
      @(posedge clk);
    end
    op_valid <= 1'b1;
    kind     <= k;
    value    <= v;
    position <= p;
    do @(posedge clk); while (!op_ready);
  endtask

  always @(posedge clk) begin
    result_ready <= ($urandom_range(0, 99) >= gap_pct);
  end

  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    if (!rst && result_valid && result_ready) begin
      got = {status, element, last, length};
      if (pending_answers.size() == 0) begin
        err_count++;
        $display("%0t: unexpected beat: status %0d element %0d last %0d length %0d",
                 $time, got.status, got.element, got.last, got.length);
      end else begin
        want = pending_answers.pop_front();
        if (got.status !== want.status || got.element !== want.element ||
            got.last !== want.last || got.length !== want.length) begin
          err_count++;
          $display({"%0t: beat mismatch: expected status %0d element %0d last %0d ",
                    "length %0d, got status %0d element %0d last %0d length %0d"},
                   $time, want.status, want.element, want.last, want.length,
                   got.status, got.element, got.last, got.length);
        end
      end
    end
  end

  initial begin
    step_t                     s;
    logic [KIND_W-1:0]         k;
    logic [VALUE_W-1:0]        v;
    logic [POS_W-1:0]          p;
    int                        roll;
    int                        fill_goal;
    int                        n;

    // directed table; typed rows carry their answer, the rest use the model
    add_step(K_DUMP,      '0,    8'd0,   1, 1, ST_EMPTY, '0, 0);
    add_step(K_DEL_FRONT, '0,    8'd0,   1, 1, ST_EMPTY, '0, 0);
    add_step(K_DEL_REAR,  '0,    8'd0,   1, 1, ST_EMPTY, '0, 0);
    add_step(K_DEL_POS,   '0,    8'd0,   1, 1, ST_EMPTY, '0, 0);
    add_step(K_INS_FRONT, V_MAX, 8'd0,   1, 1, ST_OK,    '0, 1);
    add_step(K_INS_REAR,  V_MIN, 8'hFF,  1, 1, ST_OK,    '0, 2);
    add_step(K_INS_FRONT, '1,    8'd0,   1, 1, ST_OK,    '0, 3);
    add_step(K_DUMP,      '0,    8'd0,   1, 0, ST_OK,    '0, 0);
    add_step(K_DEL_POS,   '0,    8'd0,   1, 1, ST_RANGE, '0, 3);
    add_step(K_DEL_POS,   '0,    8'd4,   1, 1, ST_RANGE, '0, 3);
    add_step(K_DEL_POS,   '0,    8'hFF,  1, 1, ST_RANGE, '0, 3);
    add_step(K_DEL_POS,   '0,    8'd2,   1, 0, ST_OK,    '0, 0);
    add_step(K_DEL_REAR,  '0,    8'd0,   1, 0, ST_OK,    '0, 0);
    add_step(K_DEL_FRONT, '0,    8'd0,   1, 0, ST_OK,    '0, 0);
    add_step(K_UNUSED_LO, V_MAX, 8'hFF,  1, 0, ST_OK,    '0, 0);
    add_step(K_UNUSED_HI, V_MIN, 8'd1,   1, 0, ST_OK,    '0, 0);
    add_step(K_INS_REAR,  32'h5A5A_0000, 8'd0, CAPACITY, 0, ST_OK, '0, 0);
    add_step(K_DUMP,      '0,    8'd0,   1, 0, ST_OK,    '0, 0);
    add_step(K_INS_FRONT, V_MAX, 8'd0,   1, 1, ST_FULL,  '0, CAPACITY);
    add_step(K_INS_REAR,  V_MIN, 8'd0,   1, 1, ST_FULL,  '0, CAPACITY);
    add_step(K_DEL_POS,   '0,    8'd16,  1, 0, ST_OK,    '0, 0);
    add_step(K_DEL_POS,   '0,    8'd1,   1, 0, ST_OK,    '0, 0);
    add_step(K_DEL_POS,   '0,    8'd15,  1, 1, ST_RANGE, '0, CAPACITY - 2);
    add_step(K_DEL_POS,   '0,    8'd14,  1, 0, ST_OK,    '0, 0);
    add_step(K_DUMP,      '0,    8'd0,   1, 0, ST_OK,    '0, 0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (steps[i]) begin
      s = steps[i];
      for (int r = 0; r < s.reps; r++) begin
        drive_op(s.kind, s.value + r, s.position);
        predict_answers(s.kind, s.value + r, s.position);
        if (s.typed) pending_answers.push_back(s.answer);
        else foreach (op_answers[j]) pending_answers.push_back(op_answers[j]);
      end
    end

    n = 0;
    fill_goal = 8;
    while (n < RANDOM_OPS) begin
      if (n % 60 == 0) fill_goal = ($urandom_range(0, 3) == 0) ? CAPACITY
                                                                : $urandom_range(0, CAPACITY);
      gap_pct = (n >= 150 && n < 230) ? 0 : 23;
      roll = $urandom_range(0, 99);
      if (roll < 3) k = $urandom_range(0, 1) ? K_UNUSED_LO : K_UNUSED_HI;
      else if (roll < 13) k = K_DUMP;
      else if ($urandom_range(0, 99) < ((list_values.size() < fill_goal) ? 75 : 25))
        k = $urandom_range(0, 1) ? K_INS_FRONT : K_INS_REAR;
      else k = KIND_W'($urandom_range(K_DEL_FRONT, K_DEL_POS));

      case ($urandom_range(0, 9))
        0: v = V_MAX;
        1: v = V_MIN;
        2: v = $urandom_range(0, 1) ? '0 : '1;
        default: v = $urandom;
      endcase

      roll = $urandom_range(0, 9);
      if (roll == 0) p = '0;
      else if (roll == 1) p = POS_W'($urandom_range(0, 255));
      else p = POS_W'($urandom_range(1, (list_values.size() > 0) ? list_values.size() : 1));

      drive_op(k, v, p);
      predict_answers(k, v, p);
      foreach (op_answers[j]) pending_answers.push_back(op_answers[j]);
      if (k != K_UNUSED_LO && k != K_UNUSED_HI) n++;
    end
    op_valid <= 1'b0;
    gap_pct = 23;

    while (pending_answers.size() != 0) @(posedge clk);
    // catch any stray beats
    repeat (40) @(posedge clk);

    if (err_count == 0 && pending_answers.size() == 0) begin
      $display("bounded_list_store test passed");
    end else begin
      $display("bounded_list_store test failed");
    end
    $finish;
  end

endmodule
